>>> rtl/core/utf8d_pkg.sv
// Shared types and constants for the UTF-8 decoder.
// Holds the decode command passed from the front end to the result expander.
// No dependencies.
package utf8d_pkg;

  // Replacement code point and the limits used by the scalar checks.
  localparam logic [20:0] ReplacementChar = 21'h00FFFD;
  localparam logic [20:0] MaxScalar       = 21'h10FFFF;
  localparam logic [20:0] SurrogateLo     = 21'h00D800;
  localparam logic [20:0] SurrogateHi     = 21'h00DFFF;
  localparam logic [20:0] MinTwoByte      = 21'h000080;
  localparam logic [20:0] MinThreeByte    = 21'h000800;
  localparam logic [20:0] MinFourByte     = 21'h010000;

  // Default depth of the command queue.
  localparam int unsigned FifoDepthDefault = 4;

  // One command per accepted byte that yields a result: rep_cnt replacements, then an optional code point.
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic        has_cp;
    logic [20:0] cp;
    logic        fin;
  } cmd_t;

endpackage

>>> rtl/core/utf8d_front.sv
// Front end of the UTF-8 decoder: accepts bytes and tracks open sequences.
// Turns each byte that yields a result into one command for the result expander.
// Depends on utf8d_pkg.
module utf8d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        text_byte_i,
  input  logic              final_byte_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output utf8d_pkg::cmd_t   cmd_o
);
  import utf8d_pkg::*;

  logic [1:0]  need_q, need_d;
  logic [1:0]  seen_q, seen_d;
  logic [20:0] part_q, part_d;

  logic        accept;
  logic        b_ascii, b_lead, b_cont;
  logic [1:0]  b_need;
  logic [20:0] b_bits;
  logic [20:0] acc;
  logic [1:0]  seen_inc;
  logic        scalar_ok;
  logic [2:0]  rep;
  logic        has_cp;
  logic [20:0] cp;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // Classify the byte as it would start a sequence.
  always_comb begin
    b_ascii = !text_byte_i[7];
    b_cont  = (text_byte_i[7:6] == 2'b10);
    b_lead  = 1'b1;
    b_need  = 2'd0;
    b_bits  = 21'd0;
    if (text_byte_i[7:5] == 3'b110) begin
      b_need = 2'd1;
      b_bits = {16'd0, text_byte_i[4:0]};
    end else if (text_byte_i[7:4] == 4'b1110) begin
      b_need = 2'd2;
      b_bits = {17'd0, text_byte_i[3:0]};
    end else if (text_byte_i[7:3] == 5'b11110) begin
      b_need = 2'd3;
      b_bits = {18'd0, text_byte_i[2:0]};
    end else begin
      b_lead = 1'b0;
    end
  end

  // Continuation accumulation and the range checks on a completed scalar.
  assign acc      = {part_q[14:0], text_byte_i[5:0]};
  assign seen_inc = seen_q + 2'd1;

  always_comb begin
    scalar_ok = 1'b1;
    if (need_q == 2'd1 && acc < MinTwoByte) scalar_ok = 1'b0;
    if (need_q == 2'd2 && acc < MinThreeByte) scalar_ok = 1'b0;
    if (need_q == 2'd3 && acc < MinFourByte) scalar_ok = 1'b0;
    if (acc > MaxScalar) scalar_ok = 1'b0;
    if (acc >= SurrogateLo && acc <= SurrogateHi) scalar_ok = 1'b0;
  end

  // Decide the command and the next sequence state for this byte.
  always_comb begin
    logic       do_begin;
    logic [2:0] base_rep;
    need_d   = need_q;
    seen_d   = seen_q;
    part_d   = part_q;
    rep      = 3'd0;
    has_cp   = 1'b0;
    cp       = {13'd0, text_byte_i};
    do_begin = 1'b0;
    base_rep = 3'd0;

    if (need_q == 2'd0) begin
      do_begin = 1'b1;
    end else if (final_byte_i && ({1'b0, seen_q} + 3'd1 < {1'b0, need_q})) begin
      // Text ends inside a sequence: one replacement, held bits dropped.
      rep    = 3'd1;
      need_d = 2'd0;
      seen_d = 2'd0;
    end else if (!b_cont) begin
      // Sequence broken: one replacement per byte held, then rescan this byte.
      base_rep = {1'b0, seen_q} + 3'd1;
      need_d   = 2'd0;
      seen_d   = 2'd0;
      do_begin = 1'b1;
    end else if (seen_inc >= need_q) begin
      // Sequence complete.
      if (scalar_ok) begin
        has_cp = 1'b1;
        cp     = acc;
      end else begin
        rep = {1'b0, need_q} + 3'd1;
      end
      need_d = 2'd0;
      seen_d = 2'd0;
    end else begin
      seen_d = seen_inc;
      part_d = acc;
    end

    if (do_begin) begin
      rep = base_rep;
      if (b_ascii) begin
        has_cp = 1'b1;
      end else if (b_lead && !final_byte_i) begin
        need_d = b_need;
        seen_d = 2'd0;
        part_d = b_bits;
      end else begin
        rep = base_rep + 3'd1;
      end
    end
  end

  assign push_o        = accept && (rep != 3'd0 || has_cp);
  assign cmd_o.rep_cnt = rep;
  assign cmd_o.has_cp  = has_cp;
  assign cmd_o.cp      = cp;
  assign cmd_o.fin     = final_byte_i;

  // Sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 2'd0;
      seen_q <= 2'd0;
    end else if (accept) begin
      need_q <= need_d;
      seen_q <= seen_d;
    end
  end

  // Partial value is overwritten whenever a sequence opens and extended by each held continuation byte.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      part_q <= part_d;
    end
  end

  a_seen_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q != 2'd0) |-> (seen_q < need_q))
    else $error("continuation count reached the sequence length");

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_byte_i) |=> (need_q == 2'd0))
    else $error("sequence left open after the final byte");

  a_final_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_byte_i) |-> push_o)
    else $error("final byte produced no command");

endmodule

>>> rtl/core/utf8d_fifo.sv
// Command queue between the decoder front end and the result expander.
// Register-based circular buffer with a head view; depends on utf8d_pkg.
module utf8d_fifo #(
  parameter int unsigned FifoDepth = utf8d_pkg::FifoDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  utf8d_pkg::cmd_t  push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             head_valid_o,
  output utf8d_pkg::cmd_t  head_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(FifoDepth);

  cmd_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/utf8d_back.sv
// Result expander of the UTF-8 decoder: turns each queued command into
// one to four code points behind an output register. Depends on utf8d_pkg.
module utf8d_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  utf8d_pkg::cmd_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [20:0]      code_point_o,
  output logic             run_last_o,
  output logic             text_done_o
);
  import utf8d_pkg::*;

  logic [2:0]  idx_q;
  logic        out_valid_q;
  logic [20:0] code_q;
  logic        run_last_q, text_done_q;

  logic [2:0]  total;
  logic        load, last;

  assign total = head_i.rep_cnt + {2'd0, head_i.has_cp};
  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign last  = (idx_q + 3'd1) == total;
  assign pop_o = load && last;

  // Index of the next beat within the head command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last ? 3'd0 : idx_q + 3'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register: replacements first, then the decoded code point.
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q      <= (idx_q < head_i.rep_cnt) ? ReplacementChar : head_i.cp;
      run_last_q  <= last;
      text_done_q <= last && head_i.fin;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = code_q;
  assign run_last_o   = run_last_q;
  assign text_done_o  = text_done_q;

  a_head_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (total != 3'd0))
    else $error("queued command carries no results");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (idx_q < total))
    else $error("beat index ran past the command");

  a_idx_zero_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> (idx_q == 3'd0))
    else $error("beat index left over with the queue empty");

endmodule

>>> rtl/core/utf8_decoder_with_replacement.sv
// Top level of the streaming UTF-8 decoder with U+FFFD replacement.
// Instantiates utf8d_front, utf8d_fifo and utf8d_back; depends on utf8d_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one text byte per beat with
//   final_byte_i marking the last byte of the text. Output channel
//   (out_valid_o / out_stall_i) gives one code point per beat; run_last_o
//   marks the last code point caused by a byte and text_done_o the last one
//   of the text.
//   A byte is decoded in the cycle it is accepted and becomes at most one
//   queued command; its first code point then passes from the command queue
//   into the output register, and a stalled receiver or a busy output
//   register can hold it back on the way.
//   Throughput is one byte per cycle while each byte yields at most one
//   code point and the receiver does not stall. A byte that yields several
//   code points (up to four, for broken or invalid sequences) holds the
//   output register for one beat each; the command queue of FifoDepth
//   entries absorbs such bursts, and the input stalls only when it is full.
//   When the receiver stalls, the presented beat holds and the queue fills.
//   Reset closes any open sequence and empties the queue and the output
//   register; no clearing pass is needed.
module utf8_decoder_with_replacement #(
  parameter int unsigned FifoDepth = utf8d_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        run_last_o,
  output logic        text_done_o
);
  import utf8d_pkg::*;

  logic q_full, push, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  // Byte classification and sequence tracking.
  utf8d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Command queue.
  utf8d_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // Result expansion and output register.
  utf8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_point_o (code_point_o),
    .run_last_o   (run_last_o),
    .text_done_o  (text_done_o)
  );

endmodule
